### sv/utd_pkg.sv
// Shared types, codes and constants of the UTF-8 to UCS-2 decoder unit.
`default_nettype none
package utd_pkg;

   localparam int unsigned QueueDepthDefault = 4;

   localparam logic [7:0] AsciiLimit     = 8'd128;
   localparam logic [7:0] ContLimit      = 8'hC0;
   localparam logic [7:0] LeadMask       = 8'hF0;
   localparam logic [7:0] Lead3Pattern   = 8'hE0;
   localparam logic [7:0] Lead4Pattern   = 8'hF0;
   localparam logic [7:0] NewlineByte    = 8'd10;

   localparam logic [0:0] DropNewlineReset = 1'b1;
   localparam logic [7:0] MaxCharsReset    = 8'd128;

   localparam int unsigned CsrAddrWidth = 3;
   localparam logic [0:0]  RegDropNewline = 1'b0;
   localparam logic [0:0]  RegMaxChars    = 1'b1;

   typedef logic [1:0] class_type;
   localparam class_type CLS_SKIP  = 2'd0;
   localparam class_type CLS_ASCII = 2'd1;
   localparam class_type CLS_LEAD2 = 2'd2;
   localparam class_type CLS_LEAD3 = 2'd3;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      class_type  kind;
   } entry_type;

   typedef struct packed {
      logic       drop_newline;
      logic [7:0] max_chars;
   } cfg_type;

endpackage
`default_nettype wire

### sv/utd_front.sv
// Front end: classifies each incoming byte and pushes it into the queue.
`default_nettype none
module utd_front
   import utd_pkg::*;
(
   input  wire logic       drop_newline,
   input  wire logic       req_valid,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_last_byte,
   input  wire logic       queue_full,
   output logic            req_stall,
   output logic            push,
   output entry_type       push_entry
);

   class_type kind;

   always_comb begin
      kind = CLS_SKIP;
      if (req_in_byte < AsciiLimit) begin
         if (!(drop_newline && (req_in_byte == NewlineByte))) begin
            kind = CLS_ASCII;
         end
      end else if (req_in_byte < ContLimit) begin
         kind = CLS_SKIP;
      end else if ((req_in_byte & LeadMask) == Lead4Pattern) begin
         kind = CLS_SKIP;
      end else if ((req_in_byte & LeadMask) == Lead3Pattern) begin
         kind = CLS_LEAD3;
      end else begin
         kind = CLS_LEAD2;
      end
   end

   assign req_stall       = queue_full;
   assign push            = req_valid && !queue_full;
   assign push_entry.data = req_in_byte;
   assign push_entry.last = req_last_byte;
   assign push_entry.kind = kind;

endmodule
`default_nettype wire

### sv/utd_queue.sv
// Short queue of classified bytes between the front and back ends.
`default_nettype none
module utd_queue
   import utd_pkg::*;
#(
   parameter int unsigned Depth = QueueDepthDefault
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output logic           full,
   output logic           not_empty,
   output entry_type      head
);

   localparam int unsigned PtrWidth   = $clog2(Depth);
   localparam int unsigned CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

   entry_type                 store_ff [Depth];
   logic [PtrWidth-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]     count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full      = (count_ff == FullCount);
   assign not_empty = (count_ff != '0);
   assign head      = store_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

### sv/utd_back.sv
// Back end: sequence assembly, output limit and the result register.
`default_nettype none
module utd_back
   import utd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      queue_not_empty,
   input  wire entry_type head,
   output logic           pop,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output logic           rsp_char_valid,
   output logic [15:0]    rsp_code_unit,
   output logic [7:0]     rsp_char_count,
   output logic           rsp_string_done
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_TWO   = 2'd1;
   localparam logic [1:0] PH_MID   = 2'd2;
   localparam logic [1:0] PH_THREE = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  lead_ff, lead_in;
   logic [5:0]  middle_ff, middle_in;
   logic [7:0]  count_ff, count_in;
   logic        out_valid_ff, out_valid_in;
   logic        char_valid_ff, char_valid_in;
   logic [15:0] code_ff, code_in;
   logic [7:0]  out_count_ff, out_count_in;
   logic        done_ff, done_in;
   logic        step_valid;
   logic [15:0] step_code;
   logic [1:0]  step_phase;
   logic [7:0]  step_count;

   assign pop = queue_not_empty && (!out_valid_ff || !rsp_stall);

   always_comb begin
      step_valid = 1'b0;
      step_code  = '0;
      step_phase = phase_ff;
      lead_in    = lead_ff;
      middle_in  = middle_ff;
      if (count_ff < cfg.max_chars) begin
         case (phase_ff)
            PH_IDLE: begin
               case (head.kind)
                  CLS_ASCII: begin
                     step_valid = 1'b1;
                     step_code  = {8'd0, head.data};
                  end
                  CLS_LEAD2: begin
                     lead_in    = head.data[4:0];
                     step_phase = PH_TWO;
                  end
                  CLS_LEAD3: begin
                     lead_in    = {1'b0, head.data[3:0]};
                     step_phase = PH_MID;
                  end
                  default: begin
                  end
               endcase
            end
            PH_TWO: begin
               step_valid = 1'b1;
               step_code  = {5'd0, lead_ff, head.data[5:0]};
               step_phase = PH_IDLE;
            end
            PH_MID: begin
               middle_in  = head.data[5:0];
               step_phase = PH_THREE;
            end
            default: begin
               step_valid = 1'b1;
               step_code  = {lead_ff[3:0], middle_ff, head.data[5:0]};
               step_phase = PH_IDLE;
            end
         endcase
      end
      step_count = count_ff + {7'd0, step_valid};

      phase_in      = phase_ff;
      count_in      = count_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      char_valid_in = char_valid_ff;
      code_in       = code_ff;
      out_count_in  = out_count_ff;
      done_in       = done_ff;
      if (pop) begin
         phase_in      = head.last ? PH_IDLE : step_phase;
         count_in      = head.last ? 8'd0 : step_count;
         out_valid_in  = 1'b1;
         char_valid_in = step_valid;
         code_in       = step_code;
         out_count_in  = step_count;
         done_in       = head.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         lead_ff      <= '0;
         middle_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         if (pop) begin
            lead_ff   <= lead_in;
            middle_ff <= middle_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      char_valid_ff <= char_valid_in;
      code_ff       <= code_in;
      out_count_ff  <= out_count_in;
      done_ff       <= done_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_char_valid  = char_valid_ff;
   assign rsp_code_unit   = code_ff;
   assign rsp_char_count  = out_count_ff;
   assign rsp_string_done = done_ff;

endmodule
`default_nettype wire

### sv/utf8_to_ucs2_decoder_unit.sv
// Top level of the UTF-8 to UCS-2 decoder unit with its register port.
//
//   Channel   Ports        Word
//   req       req_*        one string byte and its last-byte flag
//   rsp       rsp_*        valid flag, code unit, running count, end of string
//   csr       csr_*        drop_newline at 0x0, max_chars at 0x4
//
// One byte is taken per cycle while req_stall is low; results pass the queue and result register.
// The queue between classifier and sequence logic holds QueueDepth words and
// absorbs output stalls; req_stall rises only when it is full.
// Reset is synchronous and bytes are accepted from the first cycle after it.
`default_nettype none
module utf8_to_ucs2_decoder_unit
   import utd_pkg::*;
#(
   parameter int unsigned QueueDepth = QueueDepthDefault
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [7:0]              req_in_byte,
   input  wire logic                    req_last_byte,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_char_valid,
   output logic [15:0]                  rsp_code_unit,
   output logic [7:0]                   rsp_char_count,
   output logic                         rsp_string_done,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   cfg_type    cfg_ff, cfg_in;
   logic       reg_sel;
   logic       csr_write;
   logic       push;
   entry_type  push_entry;
   logic       pop;
   logic       queue_full;
   logic       queue_not_empty;
   entry_type  head;

   assign reg_sel    = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_sel)
            RegDropNewline: cfg_in.drop_newline = csr_pwdata[0];
            RegMaxChars:    cfg_in.max_chars    = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         RegDropNewline: csr_prdata = {31'd0, cfg_ff.drop_newline};
         RegMaxChars:    csr_prdata = {24'd0, cfg_ff.max_chars};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drop_newline <= DropNewlineReset;
         cfg_ff.max_chars    <= MaxCharsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   utd_front u_front (
      .drop_newline  (cfg_ff.drop_newline),
      .req_valid     (req_valid),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .queue_full    (queue_full),
      .req_stall     (req_stall),
      .push          (push),
      .push_entry    (push_entry)
   );

   utd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   utd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .queue_not_empty (queue_not_empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_char_count  (rsp_char_count),
      .rsp_string_done (rsp_string_done)
   );

endmodule
`default_nettype wire
